// ===== design/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  localparam int unsigned SpqCapacity = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned FillW      = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic load;
    logic sel_new;
    logic sel_left;
    logic sel_right;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/sorted_priority_queue_unit.sv =====
// Bounded priority queue of CAPACITY entries kept in ascending priority order in a row of
// cells, each holding one value and its signed priority. Every cell compares its priority
// with the incoming key in parallel to find where an insert goes in the row of cells; a
// new item is taken every cycle while the result register can be emptied; the result
// register holds one finished item. An insert goes in front of the head on a tie with it,
// behind the tail on a tie with it, and otherwise ahead of the first entry with equal or
// larger priority; cells at and behind that point shift back by one. A remove returns the
// head and shifts every cell forward by one. A remove on an empty queue reports status 1,
// an insert into a full queue reports status 2 and is dropped; removed_value is zero for
// every result except a successful remove. fill_count carries the low 5 bits of the count.
`default_nettype none
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = SpqCapacity
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // value[31:0], priority_req[63:32]
  input  wire logic        in_tuser,   // func[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // removed_value[31:0], now_empty[32], fill_count[37:33]
  output logic [1:0]       out_tuser   // status[1:0]
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]         cnt_r;
  logic [CntW-1:0]         cnt_nxt;
  logic                    out_valid_r;
  logic [DataW-1:0]        out_value_r;
  logic [DataW-1:0]        out_value_nxt;
  status_t                 out_status_r;
  status_t                 out_status_nxt;
  logic                    out_empty_r;
  logic [FillW-1:0]        out_fill_r;
  logic [31:0]             cnt_ext;

  logic                    accept;
  func_t                   func;
  logic signed [DataW-1:0] key;
  entry_t                  new_ent;
  logic                    is_full;
  logic                    is_empty;
  logic                    do_insert;
  logic                    do_remove;

  entry_t                  ent     [CAPACITY];
  logic [CAPACITY-1:0]     ge;
  logic [CAPACITY-1:0]     valid;
  logic [CAPACITY-1:0]     tail_hit_v;
  logic [CAPACITY-1:0]     at_after;
  cell_ctl_t               ctl     [CAPACITY];
  logic                    head_hit;
  logic                    tail_hit;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign func      = func_t'(in_tuser);
  assign key       = in_tdata[63:32];
  assign new_ent   = '{value: in_tdata[31:0], prio: in_tdata[63:32]};
  assign is_full   = (cnt_r == CntW'(CAPACITY));
  assign is_empty  = (cnt_r == '0);
  assign do_insert = accept && (func == FUNC_INSERT) && !is_full;
  assign do_remove = accept && (func == FUNC_REMOVE) && !is_empty;

  assign head_hit = !valid[0] || ge[0];
  assign tail_hit = |tail_hit_v;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid[i] = (CntW'(i) < cnt_r);
    if (i == CAPACITY - 1) begin : g_last
      assign tail_hit_v[i] = valid[i] && !ge[i] || valid[i] && (ent[i].prio == key);
    end else begin : g_mid
      assign tail_hit_v[i] = valid[i] && !valid[i+1] && (key >= ent[i].prio);
    end

    assign at_after[i] = head_hit ? 1'b1 :
                         tail_hit ? !valid[i] : (ge[i] || !valid[i]);

    if (i == 0) begin : g_first
      assign ctl[i] = '{load: do_insert ? at_after[i] : do_remove, sel_new: do_insert,
                        sel_left: 1'b0, sel_right: do_remove};
      spq_cell u_cell (
        .clk     (clk),
        .ctl_i   (ctl[i]),
        .new_i   (new_ent),
        .left_i  (ent[i]),
        .right_i (ent[i+1]),
        .key_i   (key),
        .ent_o   (ent[i]),
        .ge_o    (ge[i])
      );
    end else begin : g_rest
      assign ctl[i] = '{load: do_insert ? at_after[i] : do_remove,
                        sel_new: do_insert && !at_after[i-1],
                        sel_left: do_insert && at_after[i-1],
                        sel_right: do_remove};
      spq_cell u_cell (
        .clk     (clk),
        .ctl_i   (ctl[i]),
        .new_i   (new_ent),
        .left_i  (ent[i-1]),
        .right_i (ent[(i == CAPACITY - 1) ? i : i + 1]),
        .key_i   (key),
        .ent_o   (ent[i]),
        .ge_o    (ge[i])
      );
    end
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    out_value_nxt  = '0;
    out_status_nxt = ST_OK;
    if (func == FUNC_INSERT) begin
      if (is_full) begin
        out_status_nxt = ST_FULL;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      if (is_empty) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        cnt_nxt       = cnt_r - 1'b1;
        out_value_nxt = ent[0].value;
      end
    end
  end

  assign cnt_ext = 32'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_empty_r  <= (cnt_nxt == '0);
      out_fill_r   <= cnt_ext[FillW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_fill_r, out_empty_r, out_value_r};
  assign out_tuser  = out_status_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("insert did not grow the queue");

  a_remove_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
    do_remove |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("remove did not shrink the queue");

  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> out_value_r == '0)
    else $error("failed item carries a value");

  a_empty_fill : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_fill_r == '0)
    else $error("empty flag with nonzero fill");

endmodule
`default_nettype wire

// ===== design/spq_cell.sv =====
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_ctl_t               ctl_i,
  input  wire entry_t                  new_i,
  input  wire entry_t                  left_i,
  input  wire entry_t                  right_i,
  input  wire logic signed [DataW-1:0] key_i,
  output entry_t                       ent_o,
  output logic                         ge_o
);

  entry_t ent_r;

  assign ent_o = ent_r;
  assign ge_o  = (ent_r.prio >= key_i);

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      if (ctl_i.sel_new) begin
        ent_r <= new_i;
      end else if (ctl_i.sel_left) begin
        ent_r <= left_i;
      end else if (ctl_i.sel_right) begin
        ent_r <= right_i;
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
  import spq_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 60;
  localparam int DrainCycles = 16;

  typedef struct packed {
    logic [31:0] removed_value;
    status_t     status;
    logic        now_empty;
    logic [4:0]  fill_count;
  } queue_outcome_t;

  typedef struct packed {
    func_t                func;
    logic [31:0]          value;
    logic signed [31:0]   prio;
    logic                 typed;
    queue_outcome_t       want;
  } spq_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  entry_t         held_entries[$];
  queue_outcome_t outcomes_due[$];
  logic           row_typed;
  queue_outcome_t row_want;
  int             mismatch_count = 0;
  int             quiet_cycles = 0;
  int             send_idle_pct = 0;
  int             ready_stall_pct = 0;
  int             pressure_reqs = 0;

  // head and tail ties, extremes, fill to full, then drain part of it
  spq_row_t directed_rows [25] = '{
    '{FUNC_REMOVE, 32'h0000_0000, 32'sh0, 1'b1, '{32'h0, ST_EMPTY, 1'b1, 5'd0}},
    '{FUNC_INSERT, 32'h1111_0001, 32'sh0, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd1}},
    '{FUNC_INSERT, 32'h8000_0000, 32'sh8000_0000, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd2}},
    '{FUNC_INSERT, 32'h7fff_ffff, 32'sh7fff_ffff, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd3}},
    '{FUNC_INSERT, 32'hffff_ffff, 32'sh8000_0000, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd4}},
    '{FUNC_INSERT, 32'h0000_0000, 32'sh7fff_ffff, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd5}},
    '{FUNC_INSERT, 32'haaaa_aaaa, 32'sh0, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd6}},
    '{FUNC_INSERT, 32'h5555_5555, 32'sh5, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd7}},
    '{FUNC_INSERT, 32'h0000_0009, -32'sd5, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd8}},
    '{FUNC_INSERT, 32'h0000_000a, 32'sh5, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd9}},
    '{FUNC_INSERT, 32'h0000_000b, 32'sd100, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd10}},
    '{FUNC_INSERT, 32'h0000_000c, -32'sd100, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd11}},
    '{FUNC_INSERT, 32'h0000_000d, 32'sh0, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd12}},
    '{FUNC_INSERT, 32'h0000_000e, 32'sh7, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd13}},
    '{FUNC_INSERT, 32'h0000_000f, -32'sd1, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd14}},
    '{FUNC_INSERT, 32'h0000_0010, 32'sh1, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd15}},
    '{FUNC_INSERT, 32'h0000_0011, 32'sh2, 1'b1, '{32'h0, ST_OK, 1'b0, 5'd16}},
    '{FUNC_INSERT, 32'hdead_beef, 32'sh3, 1'b1, '{32'h0, ST_FULL, 1'b0, 5'd16}},
    '{FUNC_REMOVE, 32'h1234_5678, 32'sh0, 1'b0, '0},
    '{FUNC_REMOVE, 32'h0000_0000, 32'sh0, 1'b0, '0},
    '{FUNC_REMOVE, 32'hffff_ffff, 32'shffff_ffff, 1'b0, '0},
    '{FUNC_REMOVE, 32'h0000_0000, 32'sh0, 1'b0, '0},
    '{FUNC_REMOVE, 32'h0000_0000, 32'sh0, 1'b0, '0},
    '{FUNC_REMOVE, 32'h0000_0000, 32'sh0, 1'b0, '0},
    '{FUNC_REMOVE, 32'h0000_0000, 32'sh0, 1'b0, '0}
  };

  sorted_priority_queue_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic queue_outcome_t apply_queue_op(func_t f, logic [31:0] v,
                                                    logic signed [31:0] p);
    queue_outcome_t r;
    entry_t         e;
    int             slot;
    r = '{32'h0, ST_OK, 1'b0, 5'd0};
    if (f == FUNC_INSERT) begin
      if (held_entries.size() >= SpqCapacity) begin
        r.status = ST_FULL;
      end else begin
        e.value = v;
        e.prio = p;
        slot = held_entries.size();
        if (held_entries.size() == 0 || p <= held_entries[0].prio) begin
          slot = 0;
        end else if (p < held_entries[$].prio) begin
          for (int i = 1; i < held_entries.size(); i++) begin
            if (held_entries[i].prio >= p) begin
              slot = i;
              break;
            end
          end
        end
        held_entries.insert(slot, e);
      end
    end else begin
      if (held_entries.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_value = held_entries[0].value;
        void'(held_entries.pop_front());
      end
    end
    r.now_empty = (held_entries.size() == 0);
    r.fill_count = 5'(held_entries.size());
    return r;
  endfunction

  task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    queue_outcome_t seen;
    queue_outcome_t want;
    queue_outcome_t model;
    if (rst_n === 1'b1) begin
      if (out_tvalid && out_tready) begin
        seen = '{out_tdata[31:0], status_t'(out_tuser), out_tdata[32], out_tdata[37:33]};
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, seen);
          mismatch_count++;
        end else begin
          want = outcomes_due.pop_front();
          note_field("removed_value", want.removed_value, seen.removed_value);
          note_field("status", 32'(want.status), 32'(seen.status));
          note_field("now_empty", 32'(want.now_empty), 32'(seen.now_empty));
          note_field("fill_count", 32'(want.fill_count), 32'(seen.fill_count));
        end
      end
      if (in_tvalid && in_tready) begin
        model = apply_queue_op(func_t'(in_tuser), in_tdata[31:0], in_tdata[63:32]);
        outcomes_due.push_back(row_typed ? row_want : model);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("** sorted_priority_queue_unit: FAILED **");
      $finish;
    end
  end

  // receiver, with a long hold-off on request
  initial begin
    int served;
    served = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != pressure_reqs) begin
        served++;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  task automatic offer_op(func_t f, logic [31:0] v, logic [31:0] p, logic typed,
                          queue_outcome_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {p, v};
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_prio();
    case ($urandom_range(3))
      0, 1: return 32'(int'($urandom_range(8)) - 4);
      2: return $urandom();
      default: begin
        if ($urandom_range(1) != 0) return 32'h8000_0000 + $urandom_range(2);
        return 32'h7fff_ffff - $urandom_range(2);
      end
    endcase
  endfunction

  initial begin
    int    phase_send;
    int    phase_stall;
    int    insert_pct;
    func_t f;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_INSERT;
    row_typed = 1'b0;
    row_want = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_op(directed_rows[i].func, directed_rows[i].value, directed_rows[i].prio,
               directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin phase_send = 0;  phase_stall = 0;  end
        1: begin phase_send = 77; phase_stall = 0;  end
        2: begin phase_send = 0;  phase_stall = 77; end
        default: begin phase_send = 17; phase_stall = 17; end
      endcase
      if (ph == 2) begin
        // output held off while inserts keep coming
        send_idle_pct = 0;
        ready_stall_pct = 0;
        pressure_reqs++;
        repeat (20) offer_op(FUNC_INSERT, $urandom(), pick_prio(), 1'b0, '0);
      end
      for (int seg = 0; seg < 4; seg++) begin
        if ($urandom_range(3) == 0) begin
          send_idle_pct = 0;
          ready_stall_pct = 0;
        end else begin
          send_idle_pct = phase_send;
          ready_stall_pct = phase_stall;
        end
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 25;
          default: insert_pct = 55;
        endcase
        repeat (25) begin
          f = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
          offer_op(f, $urandom(), pick_prio(), 1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    ready_stall_pct = 0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && outcomes_due.size() == 0) begin
      $display("** sorted_priority_queue_unit: PASSED **");
    end else begin
      $display("** sorted_priority_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
